// File: rtl/request_frame_parser_macros.svh
// ----------------------------------------------------------------------------
// Request frame parser assertion macros
// Shared concurrent assertion forms, clocked on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef REQUEST_FRAME_PARSER_MACROS_SVH
`define REQUEST_FRAME_PARSER_MACROS_SVH

// Same-cycle implication.
`define RFP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define RFP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/rfp_pkg.sv
// ----------------------------------------------------------------------------
// Request frame parser package
// Payload types, widths and status codes shared by the parser modules.
// ----------------------------------------------------------------------------
package rfp_pkg;

   localparam int IDX_W = 18;

   localparam logic [IDX_W-1:0] ARG_LIMIT_DEFAULT = IDX_W'(200 * 1000);

   localparam logic [1:0] STATUS_CONT   = 2'd0;
   localparam logic [1:0] STATUS_ACCEPT = 2'd1;
   localparam logic [1:0] STATUS_REJECT = 2'd2;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       msg_last;
   } req_type;

   typedef struct packed {
      logic [7:0]       arg_byte;
      logic             byte_valid;
      logic [IDX_W-1:0] arg_index;
      logic             arg_end;
      logic [1:0]       status;
   } rsp_type;

endpackage

// File: rtl/rfp_parser.sv
// ----------------------------------------------------------------------------
// Request frame parser state machine
// Holds the parse state and computes one result per accepted request byte.
// ----------------------------------------------------------------------------
module rfp_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [rfp_pkg::IDX_W-1:0] max_args,
   input  logic                     take,
   input  rfp_pkg::req_type         req_data,
   output rfp_pkg::rsp_type         rsp_next
);
   import rfp_pkg::*;

   typedef enum logic [1:0] {
      PH_COUNT,
      PH_LEN,
      PH_DATA,
      PH_DONE
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [1:0]       fcnt_ff, fcnt_in;
   logic [23:0]      shift_ff, shift_in;     // top byte never needs storing
   logic [IDX_W-1:0] total_ff, total_in;
   logic [IDX_W-1:0] argc_ff, argc_in;
   logic [31:0]      remain_ff, remain_in;
   logic             bad_ff, bad_in;

   logic [31:0]      field_value;
   logic [IDX_W-1:0] argc_inc;
   logic [31:0]      remain_dec;
   logic             field_done;

   assign field_value = {req_data.in_byte, shift_ff};
   assign field_done  = (fcnt_ff == 2'd3);
   assign argc_inc    = argc_ff + IDX_W'(1);
   assign remain_dec  = remain_ff - 32'd1;

   always_comb begin
      phase_in  = phase_ff;
      fcnt_in   = fcnt_ff;
      shift_in  = shift_ff;
      total_in  = total_ff;
      argc_in   = argc_ff;
      remain_in = remain_ff;
      bad_in    = bad_ff;
      rsp_next  = '0;

      // shared 32-bit field assembly for the count and length phases
      if (!bad_ff && (phase_ff == PH_COUNT || phase_ff == PH_LEN)) begin
         if (field_done) begin
            fcnt_in  = 2'd0;
            shift_in = '0;
         end else begin
            fcnt_in = fcnt_ff + 2'd1;
            case (fcnt_ff)
               2'd0:    shift_in[7:0]   = req_data.in_byte;
               2'd1:    shift_in[15:8]  = req_data.in_byte;
               2'd2:    shift_in[23:16] = req_data.in_byte;
               default: shift_in        = shift_ff;
            endcase
         end
      end

      if (!bad_ff) begin
         case (phase_ff)
            PH_COUNT: begin
               if (field_done) begin
                  if (field_value > {{(32-IDX_W){1'b0}}, max_args}) begin
                     bad_in = 1'b1;
                  end else begin
                     total_in = field_value[IDX_W-1:0];
                     argc_in  = '0;
                     phase_in = (field_value[IDX_W-1:0] == '0) ? PH_DONE : PH_LEN;
                  end
               end
            end
            PH_LEN: begin
               if (field_done) begin
                  remain_in = field_value;
                  if (field_value == 32'd0) begin
                     rsp_next.arg_end   = 1'b1;
                     rsp_next.arg_index = argc_ff;
                     argc_in  = argc_inc;
                     phase_in = (argc_inc == total_ff) ? PH_DONE : PH_LEN;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               rsp_next.arg_byte   = req_data.in_byte;
               rsp_next.byte_valid = 1'b1;
               rsp_next.arg_index  = argc_ff;
               remain_in = remain_dec;
               if (remain_dec == 32'd0) begin
                  rsp_next.arg_end = 1'b1;
                  argc_in  = argc_inc;
                  phase_in = (argc_inc == total_ff) ? PH_DONE : PH_LEN;
               end
            end
            PH_DONE: begin
               bad_in = 1'b1;   // trailing byte
            end
            default: begin
               bad_in = 1'b1;
            end
         endcase
      end

      // final byte: verdict, then back to the start of a message
      if (req_data.msg_last) begin
         rsp_next.status = (!bad_in && phase_in == PH_DONE) ? STATUS_ACCEPT
                                                            : STATUS_REJECT;
         phase_in  = PH_COUNT;
         fcnt_in   = 2'd0;
         shift_in  = '0;
         total_in  = '0;
         argc_in   = '0;
         remain_in = '0;
         bad_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_COUNT;
         fcnt_ff   <= 2'd0;
         shift_ff  <= '0;
         total_ff  <= '0;
         argc_ff   <= '0;
         remain_ff <= '0;
         bad_ff    <= 1'b0;
      end else if (take) begin
         phase_ff  <= phase_in;
         fcnt_ff   <= fcnt_in;
         shift_ff  <= shift_in;
         total_ff  <= total_in;
         argc_ff   <= argc_in;
         remain_ff <= remain_in;
         bad_ff    <= bad_in;
      end
   end

endmodule

// File: rtl/rfp_out_stage.sv
// ----------------------------------------------------------------------------
// Request frame parser output stage
// Result register with valid/stall handshake toward the receiver.
// ----------------------------------------------------------------------------
module rfp_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  rfp_pkg::rsp_type rsp_next,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output rfp_pkg::rsp_type rsp_data,
   output logic             hold
);
   import rfp_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // full and not drained this cycle
   assign hold     = valid_ff & rsp_stall;
   assign valid_in = load | hold;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_next;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// File: rtl/request_frame_parser.sv
// ----------------------------------------------------------------------------
// Request frame parser
// Deframes length-prefixed request messages into argument data bytes.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one message byte per request (in_byte, msg_last on the final
//            byte). Accepted when req_valid is high and req_stall is low.
//   rsp_*  : one result per request: data byte with argument index, an
//            end-of-argument mark, and on the final byte accept or reject.
//   csr_*  : write of max_args (largest argument count per message);
//            csr_ready is always high. Write only while the block is idle.
// The result is registered: a request accepted in one cycle has its result
// on rsp_data in the cycle after. Throughput is one request per cycle when
// rsp_stall is low; the parse state keeps pace, so bytes stream back to back.
// When the receiver stalls, the result register holds and req_stall rises
// until the result is taken; a request is still taken in the cycle the
// held result drains.
// Reset clears the parse state and the output valid flag, and sets max_args
// to 200000. After each final byte the parser returns to the start state.
// ----------------------------------------------------------------------------
`include "request_frame_parser_macros.svh"

module request_frame_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  rfp_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rfp_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [rfp_pkg::IDX_W-1:0] csr_data
);
   import rfp_pkg::*;

   logic [IDX_W-1:0] max_args_ff;
   logic             take;
   logic             hold;
   rsp_type          rsp_next;

   // config register, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_args_ff <= ARG_LIMIT_DEFAULT;
      end else if (csr_valid && csr_ready) begin
         max_args_ff <= csr_data;
      end
   end

   // a request moves in whenever the result register is free or draining
   assign req_stall = hold;
   assign take      = req_valid & ~hold;

   rfp_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .max_args (max_args_ff),
      .take     (take),
      .req_data (req_data),
      .rsp_next (rsp_next)
   );

   rfp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (take),
      .rsp_next  (rsp_next),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .hold      (hold)
   );

   // checks
   `RFP_ASSERT_NEXT(a_status_only_on_last, req_valid && !req_stall && !req_data.msg_last, rsp_data.status == STATUS_CONT, "verdict on a byte that is not the final one")
   `RFP_ASSERT_NOW(a_stall_needs_result, req_stall, rsp_valid, "request stalled with no result pending")
   `RFP_ASSERT_NOW(a_idle_index_zero, rsp_valid && !rsp_data.byte_valid && !rsp_data.arg_end, rsp_data.arg_index == '0, "argument index set on a result with no data or end mark")

endmodule
